// File: rtl/dotq_pkg.sv
// Package for the date ordered task queue: sizes, command and status codes,
// request/response/slot/store-control structs and the sequencer state type. No dependencies.
`default_nettype none

package dotq_pkg;

    localparam int TASKS   = 16;
    localparam int IDX_W   = (TASKS > 1) ? $clog2(TASKS) : 1;
    localparam int CNT_W   = $clog2(TASKS + 1);
    localparam int CMD_W   = 2;
    localparam int ID_W    = 4;
    localparam int DATE_W  = 32;
    localparam int STAT_W  = 2;
    localparam int QCNT_W  = 5;
    localparam int IDS     = 1 << ID_W;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

    localparam logic [STAT_W-1:0] ST_DONE       = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOT_DUE    = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOT_QUEUED = 2'd2;
    localparam logic [STAT_W-1:0] ST_ALREADY    = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [ID_W-1:0]   task_id;
        logic [DATE_W-1:0] date;
    } t_req;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ID_W-1:0]   task_out;
        logic [DATE_W-1:0] task_date;
        logic [QCNT_W-1:0] queued_count;
    } t_rsp;

    typedef struct packed {
        logic [DATE_W-1:0] date;
        logic [ID_W-1:0]   task_id;
    } t_slot;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        t_slot            wdata;
        logic [IDX_W-1:0] raddr;
    } t_ram_ctl;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_HEAD,
        S_INS_TAIL,
        S_INS_WALK,
        S_INS_LAST,
        S_RM_WALK,
        S_FINISH
    } t_state;

endpackage

`default_nettype wire

// File: rtl/dotq_ram.sv
// Slot store: one write port, one registered read port.
// Depends on dotq_pkg.
`default_nettype none

module dotq_ram (
    input  wire                i_clk,
    input  dotq_pkg::t_ram_ctl i_ctl,
    output dotq_pkg::t_slot    o_rd
);
    import dotq_pkg::*;

    t_slot r_mem [TASKS];
    t_slot r_rd;

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_ctl.waddr] <= i_ctl.wdata;
        end
        r_rd <= r_mem[i_ctl.raddr];
    end

    assign o_rd = r_rd;

endmodule

`default_nettype wire

// File: rtl/dotq_ctrl.sv
// Sequencer: walks the slot store one entry per cycle to insert, pop or remove.
// Holds entry count and queued flags. Depends on dotq_pkg.
`default_nettype none

module dotq_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_req_valid,
    input  dotq_pkg::t_req      i_req,
    output logic                o_req_ready,
    input  dotq_pkg::t_slot     i_rd,
    output dotq_pkg::t_ram_ctl  o_ram,
    input  wire                 i_rsp_free,
    output logic                o_rsp_valid,
    output dotq_pkg::t_rsp      o_rsp
);
    import dotq_pkg::*;

    t_state             r_state, n_state;
    logic [CMD_W-1:0]   r_cmd, n_cmd;
    logic [ID_W-1:0]    r_id, n_id;
    logic [DATE_W-1:0]  r_date, n_date;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [IDS-1:0]     r_flags, n_flags;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic               r_found, n_found;
    logic               r_head_lt, n_head_lt;
    logic [STAT_W-1:0]  r_status, n_status;
    logic [ID_W-1:0]    r_tout, n_tout;
    logic [DATE_W-1:0]  r_tdate, n_tdate;

    logic               w_accept;
    logic               w_in_flag;
    logic               w_id_bad;
    logic               w_full;
    logic               w_empty;
    logic [CNT_W-1:0]   w_cnt_m1;
    logic [IDX_W-1:0]   w_tail_idx;
    logic [IDX_W-1:0]   w_cnt_idx;
    logic               w_last;
    logic               w_append;
    logic               w_move;
    logic               w_idx_zero;
    logic               w_is_pop;
    logic               w_hit;
    t_slot              w_new;

    assign w_accept   = i_req_valid && (r_state == S_IDLE);
    assign w_in_flag  = r_flags[i_req.task_id];
    assign w_id_bad   = 32'(i_req.task_id) >= 32'(TASKS);
    assign w_full     = r_count == CNT_W'(TASKS);
    assign w_empty    = r_count == '0;
    assign w_cnt_m1   = r_count - CNT_W'(1);
    assign w_tail_idx = w_cnt_m1[IDX_W-1:0];
    assign w_cnt_idx  = r_count[IDX_W-1:0];
    assign w_last     = CNT_W'(r_idx) == w_cnt_m1;
    assign w_append   = r_head_lt && (i_rd.date <= r_date);
    assign w_move     = i_rd.date >= r_date;
    assign w_idx_zero = r_idx == '0;
    assign w_is_pop   = r_cmd == CMD_POP;
    assign w_hit      = w_is_pop ? (i_rd.date <= r_date) : (i_rd.task_id == r_id);
    assign w_new      = '{date: r_date, task_id: r_id};

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (i_req.cmd)
                        CMD_INSERT: begin
                            if (w_id_bad || w_in_flag || w_full || w_empty) begin
                                n_state = S_FINISH;
                            end else begin
                                n_state = S_INS_HEAD;
                            end
                        end
                        CMD_POP:    n_state = w_empty ? S_FINISH : S_RM_WALK;
                        CMD_REMOVE: n_state = w_in_flag ? S_RM_WALK : S_FINISH;
                        default:    n_state = S_FINISH;
                    endcase
                end
            end
            S_INS_HEAD: n_state = S_INS_TAIL;
            S_INS_TAIL: n_state = w_append ? S_FINISH : S_INS_WALK;
            S_INS_WALK: begin
                if (!w_move) begin
                    n_state = S_FINISH;
                end else if (w_idx_zero) begin
                    n_state = S_INS_LAST;
                end
            end
            S_INS_LAST: n_state = S_FINISH;
            S_RM_WALK: begin
                if (r_found || w_hit) begin
                    if (w_last) begin
                        n_state = S_FINISH;
                    end
                end else if (w_is_pop || w_last) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_rsp_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and store control
    always_comb begin
        n_cmd     = r_cmd;
        n_id      = r_id;
        n_date    = r_date;
        n_count   = r_count;
        n_flags   = r_flags;
        n_idx     = r_idx;
        n_found   = r_found;
        n_head_lt = r_head_lt;
        n_status  = r_status;
        n_tout    = r_tout;
        n_tdate   = r_tdate;
        o_ram     = '{we: 1'b0, waddr: '0, wdata: w_new, raddr: '0};

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_cmd    = i_req.cmd;
                    n_id     = i_req.task_id;
                    n_date   = i_req.date;
                    n_tout   = '0;
                    n_tdate  = '0;
                    n_found  = 1'b0;
                    n_idx    = '0;
                    n_status = ST_NOT_DUE;
                    unique case (i_req.cmd)
                        CMD_INSERT: begin
                            if (w_id_bad) begin
                                n_status = ST_NOT_QUEUED;
                            end else if (w_in_flag) begin
                                n_status = ST_ALREADY;
                            end else if (w_full) begin
                                n_status = ST_NOT_QUEUED;
                            end else if (w_empty) begin
                                o_ram.we    = 1'b1;
                                o_ram.waddr = '0;
                                o_ram.wdata = '{date: i_req.date, task_id: i_req.task_id};
                                n_count     = r_count + CNT_W'(1);
                                n_flags[i_req.task_id] = 1'b1;
                                n_status    = ST_DONE;
                            end
                        end
                        CMD_POP:    n_status = ST_NOT_DUE;
                        CMD_REMOVE: n_status = ST_NOT_QUEUED;
                        default:    n_status = ST_NOT_DUE;
                    endcase
                end
            end
            S_INS_HEAD: begin
                n_head_lt   = i_rd.date < r_date;
                o_ram.raddr = w_tail_idx;
            end
            S_INS_TAIL: begin
                if (w_append) begin
                    o_ram.we    = 1'b1;
                    o_ram.waddr = w_cnt_idx;
                    n_count     = r_count + CNT_W'(1);
                    n_flags[r_id] = 1'b1;
                    n_status    = ST_DONE;
                end else begin
                    o_ram.raddr = w_tail_idx;
                    n_idx       = w_tail_idx;
                end
            end
            S_INS_WALK: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = r_idx + IDX_W'(1);
                if (w_move) begin
                    o_ram.wdata = i_rd;
                    o_ram.raddr = r_idx - IDX_W'(1);
                    n_idx       = r_idx - IDX_W'(1);
                end else begin
                    n_count       = r_count + CNT_W'(1);
                    n_flags[r_id] = 1'b1;
                    n_status      = ST_DONE;
                end
            end
            S_INS_LAST: begin
                o_ram.we      = 1'b1;
                o_ram.waddr   = '0;
                n_count       = r_count + CNT_W'(1);
                n_flags[r_id] = 1'b1;
                n_status      = ST_DONE;
            end
            S_RM_WALK: begin
                o_ram.raddr = r_idx + IDX_W'(1);
                if (r_found) begin
                    // close the gap: entry moves down one slot
                    o_ram.we    = 1'b1;
                    o_ram.waddr = r_idx - IDX_W'(1);
                    o_ram.wdata = i_rd;
                    if (w_last) begin
                        n_count         = r_count - CNT_W'(1);
                        n_flags[r_tout] = 1'b0;
                        n_status        = ST_DONE;
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end else if (w_hit) begin
                    n_found = 1'b1;
                    n_tout  = i_rd.task_id;
                    n_tdate = i_rd.date;
                    if (w_last) begin
                        n_count                = r_count - CNT_W'(1);
                        n_flags[i_rd.task_id]  = 1'b0;
                        n_status               = ST_DONE;
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end else if (!w_is_pop && !w_last) begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_FINISH: begin
                n_found = r_found;
            end
            default: begin
                n_found = r_found;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_flags <= '0;
            r_found <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_flags <= n_flags;
            r_found <= n_found;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_id      <= n_id;
        r_date    <= n_date;
        r_idx     <= n_idx;
        r_head_lt <= n_head_lt;
        r_status  <= n_status;
        r_tout    <= n_tout;
        r_tdate   <= n_tdate;
    end

    assign o_req_ready = r_state == S_IDLE;
    assign o_rsp_valid = (r_state == S_FINISH) && i_rsp_free;
    assign o_rsp       = '{status: r_status, task_out: r_tout, task_date: r_tdate,
                           queued_count: QCNT_W'(r_count)};

endmodule

`default_nettype wire

// File: rtl/date_ordered_task_queue.sv
// Date ordered task queue: after a request is taken, the sequencer walks the slot store
// (insert: head read, tail read, then one slot per cycle walking down from the tail;
// pop/remove: one slot per cycle walking up from the head). One request at a time: the
// next is taken only once the last response is handed over, so a response stall holds it off.
// The single read port of the slot store sets the walk to one entry per cycle.
// Reset (synchronous, active low) empties the queue and clears all queued flags.
`default_nettype none

module date_ordered_task_queue (
    input  wire             i_clk,
    input  wire             i_rst_n,
    // request channel
    input  wire             i_in_valid,
    output logic            o_in_ready,
    input  dotq_pkg::t_req  i_in,
    // response channel
    output logic            o_out_valid,
    input  wire             i_out_ready,
    output dotq_pkg::t_rsp  o_out
);
    import dotq_pkg::*;

    t_ram_ctl w_ram;
    t_slot    w_rd;
    logic     w_rsp_free;
    logic     w_rsp_valid;
    t_rsp     w_rsp;

    logic     r_out_valid;
    t_rsp     r_out;

    // sequencer: owns count, flags and the walk over the slots
    dotq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_in_valid),
        .i_req       (i_in),
        .o_req_ready (o_in_ready),
        .i_rd        (w_rd),
        .o_ram       (w_ram),
        .i_rsp_free  (w_rsp_free),
        .o_rsp_valid (w_rsp_valid),
        .o_rsp       (w_rsp)
    );

    // slot store, sorted ascending by date in slots 0 .. count-1
    dotq_ram u_ram (
        .i_clk (i_clk),
        .i_ctl (w_ram),
        .o_rd  (w_rd)
    );

    // output register: the sequencer hands over only when this is free
    // or is being emptied in the same cycle
    assign w_rsp_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_rsp_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rsp_valid) begin
            r_out <= w_rsp;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

// File: rtl/dotq_checker.sv
// Port-level checks for the date ordered task queue, bound to the top level.
// Depends on dotq_pkg and date_ordered_task_queue.
`default_nettype none

module dotq_checker (
    input wire             i_clk,
    input wire             i_rst_n,
    input wire             i_in_valid,
    input wire             o_in_ready,
    input dotq_pkg::t_req  i_in,
    input wire             o_out_valid,
    input wire             i_out_ready,
    input dotq_pkg::t_rsp  o_out
);
    import dotq_pkg::*;

    // reset empties the output register
    a_rst_clear: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("response valid after reset");

    // one request in flight: ready drops after an accept
    a_one_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("request accepted while busy");

    // a failed command carries no task
    a_zero_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.status != ST_DONE)
            |-> (o_out.task_out == '0) && (o_out.task_date == '0))
        else $error("task fields set on failed command");

    // count never beyond capacity
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> 32'(o_out.queued_count) <= 32'(TASKS))
        else $error("queued count beyond capacity");

    // stalled response holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("stalled response changed");

endmodule

bind date_ordered_task_queue dotq_checker u_dotq_checker (.*);

`default_nettype wire

// File: tb/sv/date_ordered_task_queue_test.sv
// Self-checking bench for the date ordered task queue: directed and random requests are
// sent through the request handshake and every response is checked against an in-bench schedule.
// Depends on dotq_pkg and date_ordered_task_queue only.

module date_ordered_task_queue_test;
    timeunit 1ns;
    timeprecision 1ps;

    import dotq_pkg::*;

    // code 3 has no name in the package; the block must treat it as a no-op
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int DRAIN_LIMIT = 20000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    t_req in_req = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    t_rsp out_rsp;

    // quiet: no sender gaps and no receiver stalls
    bit quiet = 1'b0;
    int stall_left = 0;
    int fail_count = 0;

    // bench copy of the queue: ascending wake dates in slots 0 .. sched_len-1
    logic [DATE_W-1:0] sched_date [TASKS];
    logic [ID_W-1:0]   sched_task [TASKS];
    int                sched_len = 0;
    logic [IDS-1:0]    sched_flags = '0;

    t_rsp due_responses [$];

    date_ordered_task_queue uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_req),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_rsp)
    );

    always begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Close the gap left by the entry at pos.
    function automatic void drop_slot(input int pos);
        int i;
        for (i = pos; i + 1 < sched_len; i++) begin
            sched_date[i] = sched_date[i + 1];
            sched_task[i] = sched_task[i + 1];
        end
        sched_len--;
    endfunction

    // Applies one request to the bench queue and gives the response it must produce.
    function automatic t_rsp schedule_command(input t_req r);
        t_rsp rsp;
        int   pos;
        int   i;
        rsp = '0;
        rsp.status = ST_NOT_DUE;
        case (r.cmd)
            CMD_INSERT: begin
                if (int'(r.task_id) >= TASKS) begin
                    rsp.status = ST_NOT_QUEUED;
                end else if (sched_flags[r.task_id]) begin
                    rsp.status = ST_ALREADY;
                end else if (sched_len < TASKS) begin
                    // head wins ties, then tail wins ties, else before first date >= new
                    if (sched_len == 0 || sched_date[0] >= r.date) begin
                        pos = 0;
                    end else if (sched_date[sched_len - 1] <= r.date) begin
                        pos = sched_len;
                    end else begin
                        pos = sched_len;
                        for (i = 1; i < sched_len; i++) begin
                            if (sched_date[i] >= r.date) begin
                                pos = i;
                                break;
                            end
                        end
                    end
                    for (i = sched_len; i > pos; i--) begin
                        sched_date[i] = sched_date[i - 1];
                        sched_task[i] = sched_task[i - 1];
                    end
                    sched_date[pos] = r.date;
                    sched_task[pos] = r.task_id;
                    sched_len++;
                    sched_flags[r.task_id] = 1'b1;
                    rsp.status = ST_DONE;
                end else begin
                    rsp.status = ST_NOT_QUEUED;
                end
            end
            CMD_POP: begin
                if (sched_len != 0 && sched_date[0] <= r.date) begin
                    rsp.task_out  = sched_task[0];
                    rsp.task_date = sched_date[0];
                    sched_flags[sched_task[0]] = 1'b0;
                    drop_slot(0);
                    rsp.status = ST_DONE;
                end
            end
            CMD_REMOVE: begin
                rsp.status = ST_NOT_QUEUED;
                if (sched_flags[r.task_id]) begin
                    for (i = 0; i < sched_len; i++) begin
                        if (sched_task[i] == r.task_id) begin
                            rsp.task_out  = r.task_id;
                            rsp.task_date = sched_date[i];
                            drop_slot(i);
                            sched_flags[r.task_id] = 1'b0;
                            rsp.status = ST_DONE;
                            break;
                        end
                    end
                end
            end
            default: ;
        endcase
        rsp.queued_count = sched_len[QCNT_W-1:0];
        return rsp;
    endfunction

    // Receiver: unless quiet, ready drops at random and is held low while stall_left counts down.
    always @(posedge clk) begin
        if (quiet) begin
            stall_left = 0;
            out_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            out_ready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 15);
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // Response check against the oldest outstanding request.
    always @(posedge clk) begin : check_responses
        t_rsp want;
        if (rst_n && out_valid && out_ready) begin
            if (due_responses.size() == 0) begin
                $error("response with no request outstanding: status %0d task %0d",
                       out_rsp.status, out_rsp.task_out);
                fail_count++;
            end else begin
                want = due_responses.pop_front();
                if (out_rsp.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, out_rsp.status);
                    fail_count++;
                end
                if (out_rsp.task_out !== want.task_out) begin
                    $error("task_out: expected %0d, got %0d", want.task_out, out_rsp.task_out);
                    fail_count++;
                end
                if (out_rsp.task_date !== want.task_date) begin
                    $error("task_date: expected %0h, got %0h", want.task_date, out_rsp.task_date);
                    fail_count++;
                end
                if (out_rsp.queued_count !== want.queued_count) begin
                    $error("queued_count: expected %0d, got %0d",
                           want.queued_count, out_rsp.queued_count);
                    fail_count++;
                end
            end
        end
    end

    // One request through the handshake; valid stays up between back-to-back requests.
    task automatic send_request(input t_req r);
        int gap;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 16);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_req   <= r;
        do @(posedge clk); while (!in_ready);
        due_responses.push_back(schedule_command(r));
    endtask

    task automatic request(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
                           input logic [DATE_W-1:0] date);
        t_req r;
        r.cmd     = cmd;
        r.task_id = id;
        r.date    = date;
        send_request(r);
    endtask

    // Hold off the sender until every response is back.
    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (due_responses.size() != 0);
    endtask

    // Dates cluster round a base so that equal dates are common, with the extremes mixed in.
    function automatic logic [DATE_W-1:0] pick_date(input logic [DATE_W-1:0] base);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3:    return $urandom();
            default: return base + $urandom_range(0, 40);
        endcase
    endfunction

    task automatic test_empty_queue();
        request(CMD_POP, 4'h0, '0);
        request(CMD_POP, 4'hF, '1);
        request(CMD_REMOVE, 4'h0, '0);
        request(CMD_REMOVE, 4'hF, '1);
        request(CMD_UNUSED, 4'hA, 32'h5555_5555);
    endtask

    task automatic test_ordering();
        request(CMD_INSERT, 4'd7, 32'd50);
        request(CMD_INSERT, 4'd5, 32'd100);
        request(CMD_INSERT, 4'd3, 32'd100);     // equal to tail: goes to tail
        request(CMD_INSERT, 4'd9, 32'd100);
        request(CMD_INSERT, 4'd1, 32'd75);      // middle
        request(CMD_INSERT, 4'd15, '1);         // latest possible date
        request(CMD_INSERT, 4'd11, 32'd100);    // equal in the middle: before the equals
        request(CMD_INSERT, 4'd0, '0);          // earliest possible date
        request(CMD_INSERT, 4'd5, 32'd10);      // double insert
        request(CMD_POP, 4'd0, '0);             // head due at date zero
        request(CMD_POP, 4'd0, 32'd49);         // head not yet due
        request(CMD_REMOVE, 4'd1, '0);
        request(CMD_REMOVE, 4'd15, '0);         // tail
        request(CMD_REMOVE, 4'd1, '0);          // no longer queued
        request(CMD_POP, 4'd0, '1);
    endtask

    // Phases of 40 requests biased to fill, drain, remove or mix, with random content.
    task automatic test_random_traffic(input int n_items, input bit allow_idle);
        int                n_done;
        int                k;
        int                kind;
        int                pick;
        int                ins_w;
        int                pop_w;
        int                rm_w;
        logic [DATE_W-1:0] base;
        logic [DATE_W-1:0] d;
        logic [ID_W-1:0]   id;
        n_done = 0;
        while (n_done < n_items) begin
            kind  = $urandom_range(0, 3);
            quiet = !allow_idle || ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 3))
                0:       base = '0;
                1:       base = 32'hFFFF_FFC0;
                default: base = $urandom();
            endcase
            case (kind)
                0:       begin ins_w = 80; pop_w = 10; rm_w = 8;  end   // fill
                1:       begin ins_w = 15; pop_w = 70; rm_w = 13; end   // drain
                2:       begin ins_w = 30; pop_w = 8;  rm_w = 60; end   // removal
                default: begin ins_w = 40; pop_w = 30; rm_w = 27; end
            endcase
            for (k = 0; k < 40 && n_done < n_items; k++) begin
                pick = $urandom_range(0, 99);
                id   = ID_W'($urandom_range(0, IDS - 1));
                d    = pick_date(base);
                if (pick < ins_w) begin
                    request(CMD_INSERT, id, d);
                    n_done++;
                end else if (pick < ins_w + pop_w) begin
                    // reference date on either side of the head date
                    if (sched_len != 0 && $urandom_range(0, 1) == 0)
                        d = sched_date[0] + $urandom_range(0, 2) - 1;
                    request(CMD_POP, id, d);
                    n_done++;
                end else if (pick < ins_w + pop_w + rm_w) begin
                    if (sched_len != 0 && $urandom_range(0, 3) != 0)
                        id = sched_task[$urandom_range(0, sched_len - 1)];
                    request(CMD_REMOVE, id, d);
                    n_done++;
                end else begin
                    request(CMD_UNUSED, id, d);
                end
            end
            if (allow_idle && $urandom_range(0, 5) == 0)
                wait_drained();
        end
    endtask

    initial begin : run
        int drain_wait;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_queue();
        test_ordering();
        wait_drained();
        test_random_traffic(880, 1'b1);
        quiet = 1'b1;
        test_random_traffic(120, 1'b0);

        in_valid <= 1'b0;
        drain_wait = 0;
        while (due_responses.size() != 0 && drain_wait < DRAIN_LIMIT) begin
            @(posedge clk);
            drain_wait++;
        end
        if (due_responses.size() != 0) begin
            $display("tb: failure");
        end else begin
            // allow any stray response to show up
            repeat (TASKS + 8) @(posedge clk);
            if (fail_count == 0)
                $display("tb: success");
            else
                $display("tb: failure");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
